>>> rtl/core/acon_pkg.sv
// ----------------------------------------------------------------------------
// acon_pkg: shared types and constants of the text console cursor engine
// Command codes passed from the parser to the executor, draw opcodes,
// character codes and the geometry bundle that comes from the registers.
// ----------------------------------------------------------------------------
package acon_pkg;

   localparam int unsigned PARAM_SLOTS_DEF = 4;
   localparam int unsigned QUEUE_DEPTH_DEF = 4;
   localparam int unsigned CELL_PIXELS     = 8;

   localparam int unsigned ACC_W   = 14;
   localparam int unsigned COL_W   = 12;
   localparam int unsigned ROW_W   = 16;
   localparam int unsigned COLOR_W = 3;
   localparam int unsigned CELL_W  = 7;
   localparam int unsigned SWID_W  = 13;

   localparam logic [ACC_W-1:0]   ACC_MAX   = 14'd16383;
   localparam logic [COL_W-1:0]   COL_MAX   = 12'd4095;
   localparam logic [ROW_W-1:0]   ROW_MAX   = 16'd65535;
   localparam logic [SWID_W-1:0]  WIDTH_MAX = 13'd4096;
   localparam logic [3:0]         SCALE_MAX = 4'd8;
   localparam logic [3:0]         SCALE_MIN = 4'd1;

   // register indexes
   localparam logic REG_SCALE = 1'b0;
   localparam logic REG_WIDTH = 1'b1;

   // character codes
   localparam logic [7:0] CH_ESC   = 8'h1B;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_BS    = 8'd8;
   localparam logic [7:0] CH_LBRK  = 8'h5B;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UP    = 8'h41;
   localparam logic [7:0] CH_DOWN  = 8'h42;
   localparam logic [7:0] CH_RIGHT = 8'h43;
   localparam logic [7:0] CH_LEFT  = 8'h44;
   localparam logic [7:0] CH_HOME  = 8'h48;
   localparam logic [7:0] CH_CLEAR = 8'h4A;
   localparam logic [7:0] CH_ERASE = 8'h4B;
   localparam logic [7:0] CH_SGR   = 8'h6D;

   // select graphic rendition parameters and color indexes
   localparam logic [ACC_W-1:0] SGR_RESET   = 14'd0;
   localparam logic [ACC_W-1:0] SGR_RED     = 14'd31;
   localparam logic [ACC_W-1:0] SGR_GREEN   = 14'd32;
   localparam logic [ACC_W-1:0] SGR_YELLOW  = 14'd33;
   localparam logic [ACC_W-1:0] SGR_BLUE    = 14'd34;
   localparam logic [ACC_W-1:0] CLEAR_ALL   = 14'd2;

   localparam logic [COLOR_W-1:0] COLOR_WHITE  = 3'd0;
   localparam logic [COLOR_W-1:0] COLOR_RED    = 3'd1;
   localparam logic [COLOR_W-1:0] COLOR_GREEN  = 3'd2;
   localparam logic [COLOR_W-1:0] COLOR_YELLOW = 3'd3;
   localparam logic [COLOR_W-1:0] COLOR_BLUE   = 3'd4;

   // draw opcodes
   localparam logic [1:0] OP_DRAW  = 2'd0;
   localparam logic [1:0] OP_BLANK = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_ERASE = 2'd3;

   localparam logic [6:0] GLYPH_SPACE = 7'd32;
   localparam logic [6:0] GLYPH_NONE  = 7'd0;

   typedef enum logic [3:0] {
      CMD_LF,
      CMD_CR,
      CMD_BS,
      CMD_GLYPH,
      CMD_UP,
      CMD_DOWN,
      CMD_RIGHT,
      CMD_LEFT,
      CMD_HOME,
      CMD_CLEAR,
      CMD_ERASE,
      CMD_COLOR
   } cmd_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [7:0]         code;
      logic [COL_W-1:0]   home_x;
      logic [ROW_W-1:0]   home_y;
      logic [COLOR_W-1:0] color;
   } entry_type;

   typedef struct packed {
      logic [3:0]        scale;
      logic [CELL_W-1:0] cell_size;
      logic [SWID_W-1:0] width;
   } geom_type;

endpackage

>>> rtl/core/ansi_text_console_cursor_engine.sv
// ----------------------------------------------------------------------------
// ansi_text_console_cursor_engine: character console with ANSI CSI parsing
// Takes character bytes, parses ESC / CSI sequences, tracks the cursor and
// emits draw commands for a glyph renderer.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one character byte per transfer (valid/ready).
//   rsp_*  : draw commands (op, glyph, pixel position, color, last); a byte
//            gives zero, one or two commands, rsp_last marks the final one.
//   csr_*  : register writes, taken on any cycle csr_we is high; index 0 is
//            the glyph scale, index 1 the screen width in pixels. Write only
//            while the block is idle.
// Order: a command for a byte is written into the command queue and then
//   into the registered output stage before it appears on rsp_*.
// Throughput: one byte per cycle while the queue has room. A backspace
//   occupies the executor for two commands; the four-entry queue between
//   parser and executor absorbs this; req_ready drops only when it is full.
// Reset: parser idle, cursor at home, color white, scale 1, width 640.
// Stall: while rsp_ready is low the result is held; the executor keeps
//   running commands that draw nothing and the parser keeps filling the
//   queue until it is full.
// ----------------------------------------------------------------------------
module ansi_text_console_cursor_engine #(
   parameter int unsigned PARAM_SLOTS = acon_pkg::PARAM_SLOTS_DEF,
   parameter int unsigned QUEUE_DEPTH = acon_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_op,
   output logic [6:0]  rsp_glyph,
   output logic [11:0] rsp_pos_x,
   output logic [15:0] rsp_pos_y,
   output logic [2:0]  rsp_color,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [12:0] csr_wdata
);
   import acon_pkg::*;

   logic [3:0]        scale_ff;
   logic [SWID_W-1:0] width_ff;
   logic [3:0]        scale_eff;
   geom_type          geom;

   logic              q_ready;
   logic              push_valid;
   entry_type         push_entry;
   logic              pop;
   logic              head_valid;
   entry_type         head_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= 4'd1;
         width_ff <= 13'd640;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_SCALE: scale_ff <= csr_wdata[3:0];
            REG_WIDTH: width_ff <= csr_wdata;
            default:   ;
         endcase
      end
   end

   // clamp register values into their usable range
   assign scale_eff      = (scale_ff == '0) ? SCALE_MIN :
                           (scale_ff > SCALE_MAX) ? SCALE_MAX : scale_ff;
   assign geom.scale     = scale_eff;
   assign geom.cell_size = {scale_eff, 3'b000};
   assign geom.width     = (width_ff > WIDTH_MAX) ? WIDTH_MAX : width_ff;

   acon_front #(
      .PARAM_SLOTS (PARAM_SLOTS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .geom          (geom),
      .q_ready       (q_ready),
      .push_valid    (push_valid),
      .push_entry    (push_entry)
   );

   acon_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .q_ready    (q_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   acon_back u_back (
      .clock      (clock),
      .reset      (reset),
      .geom       (geom),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_op     (rsp_op),
      .rsp_glyph  (rsp_glyph),
      .rsp_pos_x  (rsp_pos_x),
      .rsp_pos_y  (rsp_pos_y),
      .rsp_color  (rsp_color),
      .rsp_last   (rsp_last)
   );

endmodule

>>> rtl/core/acon_front.sv
// ----------------------------------------------------------------------------
// acon_front: escape sequence parser
// Accepts one byte per cycle while the queue has room, tracks ESC / CSI state
// and parameters and turns each byte with an effect into an executor command.
// ----------------------------------------------------------------------------
module acon_front #(
   parameter int unsigned PARAM_SLOTS = acon_pkg::PARAM_SLOTS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_char_code,
   input  acon_pkg::geom_type  geom,
   input  logic                q_ready,
   output logic                push_valid,
   output acon_pkg::entry_type push_entry
);
   import acon_pkg::*;

   localparam int unsigned CNT_W = $clog2(PARAM_SLOTS + 1);
   localparam int unsigned IDX_W = $clog2(PARAM_SLOTS);

   logic             esc_ff, esc_in;
   logic             seq_ff, seq_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [ACC_W-1:0] slot_ff [PARAM_SLOTS];
   logic [ACC_W-1:0] slot_in [PARAM_SLOTS];

   logic             accept;
   logic             do_push;
   logic             do_clear;
   logic             room;
   logic [17:0]      acc_wide;
   logic [ACC_W-1:0] acc_next;
   logic [ACC_W-1:0] p0, p1;
   logic [ACC_W-1:0] row_arg, col_arg;
   logic [17:0]      row_prod, col_prod;
   logic [20:0]      row_pix, col_pix;
   logic [7:0]       ch;

   assign ch        = req_char_code;
   assign req_ready = q_ready;
   assign accept    = req_valid && q_ready;
   assign room      = (count_ff < CNT_W'(PARAM_SLOTS));

   // decimal accumulate with saturation
   assign acc_wide = (18'(acc_ff) << 3) + (18'(acc_ff) << 1) + 18'(ch[3:0]);
   assign acc_next = (acc_wide > 18'(ACC_MAX)) ? ACC_MAX : acc_wide[ACC_W-1:0];

   // the pending accumulator counts as the parameter being closed
   assign p0 = (count_ff == CNT_W'(0)) ? acc_ff : slot_ff[0];
   assign p1 = (count_ff == CNT_W'(1)) ? acc_ff : slot_ff[1];

   // cursor position: one-based row/column times cell size, saturated
   assign row_arg  = (p0 == '0) ? '0 : p0 - ACC_W'(1);
   assign col_arg  = (p1 == '0) ? '0 : p1 - ACC_W'(1);
   assign row_prod = 18'(row_arg) * 18'(geom.scale);
   assign col_prod = 18'(col_arg) * 18'(geom.scale);
   assign row_pix  = {row_prod, 3'b000};
   assign col_pix  = {col_prod, 3'b000};

   always_comb begin
      esc_in     = esc_ff;
      seq_in     = seq_ff;
      count_in   = count_ff;
      acc_in     = acc_ff;
      do_push    = 1'b0;
      do_clear   = 1'b0;
      push_valid = 1'b0;
      push_entry.cmd    = CMD_GLYPH;
      push_entry.code   = ch;
      push_entry.home_x = (col_pix > 21'(COL_MAX)) ? COL_MAX : col_pix[COL_W-1:0];
      push_entry.home_y = (row_pix > 21'(ROW_MAX)) ? ROW_MAX : row_pix[ROW_W-1:0];
      push_entry.color  = COLOR_WHITE;

      if (accept) begin
         if (esc_ff) begin
            esc_in = 1'b0;
            if (ch == CH_LBRK) begin
               seq_in   = 1'b1;
               count_in = '0;
               acc_in   = '0;
               do_clear = 1'b1;
            end
         end else if (seq_ff) begin
            if (ch >= CH_ZERO && ch <= CH_NINE) begin
               acc_in = acc_next;
            end else if (ch == CH_SEMI) begin
               do_push = 1'b1;
               acc_in  = '0;
            end else begin
               do_push = 1'b1;
               seq_in  = 1'b0;
               unique case (ch)
                  CH_UP: begin
                     push_valid     = 1'b1;
                     push_entry.cmd = CMD_UP;
                  end
                  CH_DOWN: begin
                     push_valid     = 1'b1;
                     push_entry.cmd = CMD_DOWN;
                  end
                  CH_RIGHT: begin
                     push_valid     = 1'b1;
                     push_entry.cmd = CMD_RIGHT;
                  end
                  CH_LEFT: begin
                     push_valid     = 1'b1;
                     push_entry.cmd = CMD_LEFT;
                  end
                  CH_HOME: begin
                     push_valid     = 1'b1;
                     push_entry.cmd = CMD_HOME;
                  end
                  CH_CLEAR: begin
                     push_valid     = (p0 == CLEAR_ALL);
                     push_entry.cmd = CMD_CLEAR;
                  end
                  CH_ERASE: begin
                     push_valid     = 1'b1;
                     push_entry.cmd = CMD_ERASE;
                  end
                  CH_SGR: begin
                     push_entry.cmd = CMD_COLOR;
                     push_valid     = 1'b1;
                     if (p0 == SGR_RESET) begin
                        push_entry.color = COLOR_WHITE;
                     end else if (p0 == SGR_RED) begin
                        push_entry.color = COLOR_RED;
                     end else if (p0 == SGR_GREEN) begin
                        push_entry.color = COLOR_GREEN;
                     end else if (p0 == SGR_YELLOW) begin
                        push_entry.color = COLOR_YELLOW;
                     end else if (p0 == SGR_BLUE) begin
                        push_entry.color = COLOR_BLUE;
                     end else begin
                        push_valid = 1'b0;
                     end
                  end
                  default: begin
                     push_valid = 1'b0;
                  end
               endcase
            end
         end else if (ch == CH_ESC) begin
            esc_in = 1'b1;
         end else begin
            push_valid = 1'b1;
            unique case (ch)
               CH_LF:   push_entry.cmd = CMD_LF;
               CH_CR:   push_entry.cmd = CMD_CR;
               CH_BS:   push_entry.cmd = CMD_BS;
               default: push_entry.cmd = CMD_GLYPH;
            endcase
         end
      end

      for (int i = 0; i < PARAM_SLOTS; i++) begin
         slot_in[i] = slot_ff[i];
         if (do_clear) begin
            slot_in[i] = '0;
         end else if (do_push && room && count_ff[IDX_W-1:0] == IDX_W'(i)) begin
            slot_in[i] = acc_ff;
         end
      end
      if (do_push && room) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff   <= 1'b0;
         seq_ff   <= 1'b0;
         count_ff <= '0;
         acc_ff   <= '0;
         for (int i = 0; i < PARAM_SLOTS; i++) begin
            slot_ff[i] <= '0;
         end
      end else begin
         esc_ff   <= esc_in;
         seq_ff   <= seq_in;
         count_ff <= count_in;
         acc_ff   <= acc_in;
         for (int i = 0; i < PARAM_SLOTS; i++) begin
            slot_ff[i] <= slot_in[i];
         end
      end
   end

endmodule

>>> rtl/core/acon_queue.sv
// ----------------------------------------------------------------------------
// acon_queue: command queue
// Small register FIFO between the parser and the executor.
// ----------------------------------------------------------------------------
module acon_queue #(
   parameter int unsigned QUEUE_DEPTH = acon_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  acon_pkg::entry_type push_entry,
   output logic                q_ready,
   input  logic                pop,
   output logic                head_valid,
   output acon_pkg::entry_type head_entry
);
   import acon_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign q_ready    = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ff];
   assign do_push    = push_valid && q_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

endmodule

>>> rtl/core/acon_back.sv
// ----------------------------------------------------------------------------
// acon_back: command executor
// Owns the cursor and color, carries out queued commands and drives the
// registered draw command output.
// ----------------------------------------------------------------------------
module acon_back (
   input  logic                clock,
   input  logic                reset,
   input  acon_pkg::geom_type  geom,
   input  logic                head_valid,
   input  acon_pkg::entry_type head_entry,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_op,
   output logic [6:0]          rsp_glyph,
   output logic [11:0]         rsp_pos_x,
   output logic [15:0]         rsp_pos_y,
   output logic [2:0]          rsp_color,
   output logic                rsp_last
);
   import acon_pkg::*;

   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COLOR_W-1:0] color_ff, color_in;
   logic               bs_ff, bs_in;
   logic               valid_ff;
   logic [1:0]         op_ff, op_in;
   logic [6:0]         glyph_ff, glyph_in;
   logic [COL_W-1:0]   x_ff, x_in;
   logic [ROW_W-1:0]   y_ff, y_in;
   logic               last_ff, last_in;

   logic               out_free;
   logic               emit;
   logic [SWID_W-1:0]  col_add;
   logic [COL_W-1:0]   col_sat;
   logic [SWID_W-1:0]  col_wrap;
   logic [ROW_W:0]     row_add;
   logic [ROW_W-1:0]   row_sat;
   logic [COL_W-1:0]   col_sub;
   logic [ROW_W-1:0]   row_sub;
   logic               col_ge;

   assign out_free = !valid_ff || rsp_ready;

   assign col_add  = SWID_W'(col_ff) + SWID_W'(geom.cell_size);
   assign col_sat  = (col_add > SWID_W'(COL_MAX)) ? COL_MAX : col_add[COL_W-1:0];
   assign col_wrap = SWID_W'(col_sat) + SWID_W'(geom.cell_size);
   assign row_add  = (ROW_W+1)'(row_ff) + (ROW_W+1)'(geom.cell_size);
   assign row_sat  = row_add[ROW_W] ? ROW_MAX : row_add[ROW_W-1:0];
   assign col_ge   = (col_ff >= COL_W'(geom.cell_size));
   assign col_sub  = col_ge ? col_ff - COL_W'(geom.cell_size) : '0;
   assign row_sub  = (row_ff >= ROW_W'(geom.cell_size)) ?
                     row_ff - ROW_W'(geom.cell_size) : '0;

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      color_in = color_ff;
      bs_in    = bs_ff;
      pop      = 1'b0;
      emit     = 1'b0;
      op_in    = OP_BLANK;
      glyph_in = GLYPH_SPACE;
      x_in     = col_ff;
      y_in     = row_ff;
      last_in  = 1'b1;

      if (head_valid) begin
         unique case (head_entry.cmd)
            CMD_LF: begin
               pop    = 1'b1;
               col_in = '0;
               row_in = row_sat;
            end
            CMD_CR: begin
               pop    = 1'b1;
               col_in = '0;
            end
            CMD_BS: begin
               // blank the cell, step back if there is room, blank again
               if (out_free) begin
                  emit = 1'b1;
                  if (!bs_ff) begin
                     last_in = 1'b0;
                     bs_in   = 1'b1;
                     col_in  = col_ge ? col_sub : col_ff;
                  end else begin
                     bs_in = 1'b0;
                     pop   = 1'b1;
                  end
               end
            end
            CMD_GLYPH: begin
               if (out_free) begin
                  emit = 1'b1;
                  pop  = 1'b1;
                  if (!head_entry.code[7]) begin
                     op_in    = OP_DRAW;
                     glyph_in = head_entry.code[6:0];
                  end
                  if (col_wrap > geom.width) begin
                     col_in = '0;
                     row_in = row_sat;
                  end else begin
                     col_in = col_sat;
                  end
               end
            end
            CMD_UP: begin
               pop    = 1'b1;
               row_in = row_sub;
            end
            CMD_DOWN: begin
               pop    = 1'b1;
               row_in = row_sat;
            end
            CMD_RIGHT: begin
               pop    = 1'b1;
               col_in = col_sat;
            end
            CMD_LEFT: begin
               pop    = 1'b1;
               col_in = col_sub;
            end
            CMD_HOME: begin
               pop    = 1'b1;
               col_in = head_entry.home_x;
               row_in = head_entry.home_y;
            end
            CMD_CLEAR: begin
               if (out_free) begin
                  emit     = 1'b1;
                  pop      = 1'b1;
                  op_in    = OP_CLEAR;
                  glyph_in = GLYPH_NONE;
                  x_in     = '0;
                  y_in     = '0;
                  col_in   = '0;
                  row_in   = '0;
               end
            end
            CMD_ERASE: begin
               // nothing to erase once the cursor is past the right edge
               if (SWID_W'(col_ff) >= geom.width) begin
                  pop = 1'b1;
               end else if (out_free) begin
                  emit  = 1'b1;
                  pop   = 1'b1;
                  op_in = OP_ERASE;
               end
            end
            CMD_COLOR: begin
               pop      = 1'b1;
               color_in = head_entry.color;
            end
            default: begin
               pop = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         color_ff <= COLOR_WHITE;
         bs_ff    <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         color_ff <= color_in;
         bs_ff    <= bs_in;
         if (emit) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         op_ff    <= op_in;
         glyph_ff <= glyph_in;
         x_ff     <= x_in;
         y_ff     <= y_in;
         last_ff  <= last_in;
      end
   end

   logic [COLOR_W-1:0] out_color_ff;

   always_ff @(posedge clock) begin
      if (emit) begin
         out_color_ff <= color_ff;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_op    = op_ff;
   assign rsp_glyph = glyph_ff;
   assign rsp_pos_x = x_ff;
   assign rsp_pos_y = y_ff;
   assign rsp_color = out_color_ff;
   assign rsp_last  = last_ff;

endmodule
